FILE: rtl/core/frba_pkg.sv
// shared types and constants of the fenced ring buffer allocator
// no dependencies

package frba_pkg;

  localparam int unsigned SIZE_W   = 25;
  localparam int unsigned FENCE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [SIZE_W-1:0] RING_SIZE_RESET = 25'h100_0000;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN_RD,
    ST_DRAIN_CHK,
    ST_PLACE,
    ST_RESP
  } frba_state_e;

endpackage

FILE: rtl/core/frba_retire_mem.sv
// retire queue storage: one write port, one read port, registered read data
// no dependencies

module frba_retire_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 81,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/fenced_ring_buffer_allocator_top.sv
// top level of the fenced ring buffer allocator: control, ring offsets, output register
// depends on frba_pkg and frba_retire_mem

// A request with mode 1 (free) pushes (release_offset, request_size, fence_tag) onto the
// retire queue, answering status 2 when the queue already holds RETIRE_DEPTH entries. A
// request with mode 0 (allocate) first retires queue entries from the head while their
// fence tag is at or below completed_fence, moving the consume offset to the end of each
// retired region, then places the region at the produce offset, wraps it to offset zero,
// or answers status 1. For each head entry an allocate reads it (ST_DRAIN_RD) and then
// tests it (ST_DRAIN_CHK); the drain stops at an empty queue or at the first entry whose
// fence has not completed: the retire queue sits in a memory with one read port and
// registered read data, and every head entry is read and tested before the next one is
// fetched. Either kind of request waits in ST_RESP while a held response in the output
// register is stalled. One request is in work at a time; a new request is accepted while
// the previous response still waits in the output register. produce == consume always
// means an empty ring. ring_size is written through ring_size_we_i and must only change
// while the block is idle; it resets to 2^24.

module fenced_ring_buffer_allocator_top #(
  parameter int unsigned RETIRE_DEPTH = 64,
  parameter int unsigned OFFSET_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              ring_size_we_i,
  input  logic [frba_pkg::SIZE_W-1:0]       ring_size_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [frba_pkg::SIZE_W-1:0]       request_size_i,
  input  logic [OFFSET_BITS-1:0]            release_offset_i,
  input  logic [frba_pkg::FENCE_W-1:0]      fence_tag_i,
  input  logic [frba_pkg::FENCE_W-1:0]      completed_fence_i,
  // response channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [frba_pkg::STATUS_W-1:0]     status_o,
  output logic [OFFSET_BITS-1:0]            region_offset_o
);

  import frba_pkg::*;

  localparam int unsigned IDX_W   = $clog2(RETIRE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(RETIRE_DEPTH + 1);
  localparam int unsigned ENTRY_W = OFFSET_BITS + SIZE_W + FENCE_W;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(RETIRE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RETIRE_DEPTH);

  frba_state_e state_q, state_d;

  logic [SIZE_W-1:0]      ring_size_q;
  logic [SIZE_W-1:0]      prod_q, prod_d;
  logic [SIZE_W-1:0]      cons_q, cons_d;
  logic [IDX_W-1:0]       head_q, head_d;
  logic [IDX_W-1:0]       tail_q, tail_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [SIZE_W-1:0]      size_q, size_d;
  logic [FENCE_W-1:0]     done_q, done_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic [OFFSET_BITS-1:0] res_ofs_q, res_ofs_d;
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [OFFSET_BITS-1:0] out_ofs_q, out_ofs_d;

  logic                   accept;
  logic                   out_free;
  logic                   mem_we;
  logic                   mem_re;
  logic [ENTRY_W-1:0]     mem_wdata;
  logic [ENTRY_W-1:0]     mem_rdata;

  // fields of the entry read from the head of the queue
  logic [OFFSET_BITS-1:0] rd_start;
  logic [SIZE_W-1:0]      rd_length;
  logic [FENCE_W-1:0]     rd_fence;
  logic                   head_retires;

  // placement arithmetic
  logic [SIZE_W:0]        end_sum;
  logic                   size_ok;
  logic                   fits_at_prod;
  logic                   fits_below_cons;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign mem_wdata = {fence_tag_i, request_size_i, release_offset_i};
  assign {rd_fence, rd_length, rd_start} = mem_rdata;
  assign head_retires = rd_fence <= done_q;

  assign end_sum         = {1'b0, prod_q} + {1'b0, size_q};
  assign size_ok         = size_q <= ring_size_q;
  assign fits_at_prod    = end_sum <= {1'b0, ring_size_q};
  assign fits_below_cons = end_sum < {1'b0, cons_q};

  frba_retire_mem #(
    .DEPTH  (RETIRE_DEPTH),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_retire_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (mode_i == MODE_FREE) ? ST_RESP : ST_DRAIN_RD;
        end
      end
      ST_DRAIN_RD: begin
        state_d = (count_q != '0) ? ST_DRAIN_CHK : ST_PLACE;
      end
      ST_DRAIN_CHK: begin
        state_d = head_retires ? ST_DRAIN_RD : ST_PLACE;
      end
      ST_PLACE: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    prod_d       = prod_q;
    cons_d       = cons_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    size_d       = size_q;
    done_d       = done_q;
    res_status_d = res_status_q;
    res_ofs_d    = res_ofs_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_ofs_d    = out_ofs_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          size_d    = request_size_i;
          done_d    = completed_fence_i;
          res_ofs_d = '0;
          if (mode_i == MODE_FREE) begin
            if (count_q == FULL_COUNT) begin
              res_status_d = STATUS_QUEUE_FULL;
            end else begin
              // free pushes straight into the queue memory
              mem_we       = 1'b1;
              tail_d       = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
              count_d      = count_q + CNT_W'(1);
              res_status_d = STATUS_OK;
            end
          end
        end
      end
      ST_DRAIN_RD: begin
        mem_re = (count_q != '0);
      end
      ST_DRAIN_CHK: begin
        if (head_retires) begin
          // consume moves past the retired region, kept modulo 2^25
          cons_d  = SIZE_W'(rd_start) + rd_length;
          head_d  = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
          count_d = count_q - CNT_W'(1);
        end
      end
      ST_PLACE: begin
        res_status_d = STATUS_NO_ROOM;
        res_ofs_d    = '0;
        if (size_ok) begin
          if (prod_q >= cons_q) begin
            if (fits_at_prod) begin
              res_status_d = STATUS_OK;
              res_ofs_d    = OFFSET_BITS'(prod_q);
              prod_d       = end_sum[SIZE_W-1:0];
            end else if (size_q < cons_q) begin
              // wrap to the start of the ring
              res_status_d = STATUS_OK;
              prod_d       = size_q;
            end
          end else if (fits_below_cons) begin
            res_status_d = STATUS_OK;
            res_ofs_d    = OFFSET_BITS'(prod_q);
            prod_d       = end_sum[SIZE_W-1:0];
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_ofs_d    = res_ofs_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ring_size_q <= RING_SIZE_RESET;
      prod_q      <= '0;
      cons_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prod_q      <= prod_d;
      cons_q      <= cons_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (ring_size_we_i) begin
        ring_size_q <= ring_size_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    size_q       <= size_d;
    done_q       <= done_d;
    res_status_q <= res_status_d;
    res_ofs_q    <= res_ofs_d;
    out_status_q <= out_status_d;
    out_ofs_q    <= out_ofs_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign region_offset_o = out_ofs_q;

endmodule
